// ===== hdl/dmc_pkg.sv =====
`default_nettype none
package dmc_pkg;

	localparam int ADDR_W = 32;
	localparam int CNT_W  = 32;

	localparam int MAX_LINES_DEF  = 64;
	localparam int ADDR_WIDTH_DEF = 32;

	localparam int OFF_W = 4;
	localparam int IDXW_W = 3;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SHIFT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_WIDTH  = 1'd1;

	localparam logic [OFF_W-1:0]  OFFSET_SHIFT_RST = 4'd4;
	localparam logic [IDXW_W-1:0] INDEX_WIDTH_RST  = 3'd3;

endpackage
`default_nettype wire

// ===== hdl/dmc_if.sv =====
`default_nettype none
interface dmc_addr_if;
	logic                       valid;
	logic                       ready;
	logic [dmc_pkg::ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface dmc_res_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [dmc_pkg::CNT_W-1:0] hit_total;
	logic [dmc_pkg::CNT_W-1:0] miss_total;

	modport source (output valid, output hit, output hit_total, output miss_total, input ready);
	modport sink   (input valid, input hit, input hit_total, input miss_total, output ready);
endinterface
`default_nettype wire

// ===== hdl/direct_mapped_cache_hit_counter.sv =====
// Pipeline: the tag and valid reads are registered when an item is accepted; the compare and the
// count update are registered when that item advances to the output register.
// Throughput: one item per cycle unless the result is stalled; a back-to-back access to the line
// just written is served from the write-forwarding register, so the tag memory port never stalls it.
// Reset: counters and configuration return to their reset values, then a clearing pass over all
// MAX_LINES entries zeroes the valid memory; no item is accepted during that pass.
`default_nettype none
module direct_mapped_cache_hit_counter #(
	parameter int MAX_LINES  = dmc_pkg::MAX_LINES_DEF,
	parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	dmc_addr_if.sink                            lookup,
	dmc_res_if.source                           result
);

	localparam int EFF_AW  = (ADDR_WIDTH < dmc_pkg::ADDR_W) ? ADDR_WIDTH : dmc_pkg::ADDR_W;
	localparam int TAG_W   = EFF_AW;
	localparam int LINE_AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int LIMIT   = $clog2(MAX_LINES + 1) - 1;
	localparam logic [63:0] MASK64 = (64'd1 << EFF_AW) - 64'd1;
	localparam logic [dmc_pkg::ADDR_W-1:0] ADDR_MASK = MASK64[dmc_pkg::ADDR_W-1:0];
	localparam logic [LINE_AW-1:0] LAST_LINE = LINE_AW'(MAX_LINES - 1);
	localparam logic [3:0] LIMIT_W = 4'(LIMIT);

	logic [dmc_pkg::OFF_W-1:0]  off_q;
	logic [dmc_pkg::IDXW_W-1:0] idxw_q;

	logic               clr_q;
	logic [LINE_AW-1:0] clr_cnt_q;

	logic               vld_mem [MAX_LINES];
	logic [TAG_W-1:0]   tag_mem [MAX_LINES];

	logic               busy_s1;
	logic [LINE_AW-1:0] line_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               rd_vld_s1;
	logic [TAG_W-1:0]   rd_tag_s1;

	logic               fwd_vld_q;
	logic [LINE_AW-1:0] fwd_line_q;
	logic [TAG_W-1:0]   fwd_tag_q;

	logic                      out_vld_q;
	logic                      hit_q;
	logic [dmc_pkg::CNT_W-1:0] hit_cnt_q;
	logic [dmc_pkg::CNT_W-1:0] miss_cnt_q;

	logic [dmc_pkg::ADDR_W-1:0] addr_m;
	logic [dmc_pkg::ADDR_W-1:0] block;
	logic [dmc_pkg::ADDR_W-1:0] tag_full;
	logic [3:0]                 ibits;
	logic [LINE_AW-1:0]         line_mask;
	logic [LINE_AW-1:0]         line_in;
	logic                       accept;
	logic                       adv_s1;
	logic                       cur_vld;
	logic [TAG_W-1:0]           cur_tag;
	logic                       hit_s1;
	logic                       miss_wr;

	// Address split
	always_comb begin
		addr_m   = lookup.address & ADDR_MASK;
		block    = addr_m >> off_q;
		ibits    = ({1'b0, idxw_q} < LIMIT_W) ? {1'b0, idxw_q} : LIMIT_W;
		tag_full = block >> ibits;
		for (int j = 0; j < LINE_AW; j++) begin
			line_mask[j] = (j < int'(ibits));
		end
		line_in = block[LINE_AW-1:0] & line_mask;
	end

	assign adv_s1       = busy_s1 && (!out_vld_q || result.ready);
	assign lookup.ready = !clr_q && (!busy_s1 || adv_s1);
	assign accept       = lookup.valid && lookup.ready;

	// Take the entry just written when the memory read raced the write
	always_comb begin
		if (fwd_vld_q && (fwd_line_q == line_s1)) begin
			cur_vld = 1'b1;
			cur_tag = fwd_tag_q;
		end else begin
			cur_vld = rd_vld_s1;
			cur_tag = rd_tag_s1;
		end
		hit_s1  = cur_vld && (cur_tag == tag_s1);
		miss_wr = adv_s1 && !hit_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= dmc_pkg::OFFSET_SHIFT_RST;
			idxw_q <= dmc_pkg::INDEX_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dmc_pkg::REG_OFFSET_SHIFT: off_q  <= cfg_wdata[dmc_pkg::OFF_W-1:0];
				dmc_pkg::REG_INDEX_WIDTH:  idxw_q <= cfg_wdata[dmc_pkg::IDXW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == LAST_LINE) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Valid memory: cleared by the sweep, set on a miss
	always_ff @(posedge clk) begin
		if (clr_q) begin
			vld_mem[clr_cnt_q] <= 1'b0;
		end else if (miss_wr) begin
			vld_mem[line_s1] <= 1'b1;
		end
		if (accept) begin
			rd_vld_s1 <= vld_mem[line_in];
		end
	end

	always_ff @(posedge clk) begin
		if (miss_wr) begin
			tag_mem[line_s1] <= tag_s1;
		end
		if (accept) begin
			rd_tag_s1 <= tag_mem[line_in];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_s1 <= line_in;
			tag_s1  <= tag_full[TAG_W-1:0];
		end
		if (miss_wr) begin
			fwd_line_q <= line_s1;
			fwd_tag_q  <= tag_s1;
		end
		if (adv_s1) begin
			hit_q <= hit_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1    <= 1'b0;
			fwd_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (adv_s1) begin
				busy_s1 <= 1'b0;
			end
			if (miss_wr) begin
				fwd_vld_q <= 1'b1;
			end
			if (adv_s1) begin
				out_vld_q <= 1'b1;
				if (hit_s1) begin
					if (hit_cnt_q != '1) begin
						hit_cnt_q <= hit_cnt_q + 1'b1;
					end
				end else if (miss_cnt_q != '1) begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_vld_q;
	assign result.hit        = hit_q;
	assign result.hit_total  = hit_cnt_q;
	assign result.miss_total = miss_cnt_q;

endmodule
`default_nettype wire
